@@ rtl/core/tcea_pkg.sv @@
// Shared constants, types and constant functions of the temperature color map.
// Holds the fixed-point coefficients and the erf table built at elaboration.
// No dependencies.
`default_nettype none

package tcea_pkg;

    // Fixed-point format: Q1.12 for colors, offsets and erf
    localparam int FRAC_BITS       = 12;
    localparam int ONE             = 1 << FRAC_BITS;
    localparam int HALF            = 1 << (FRAC_BITS - 1);

    // Erf table geometry: DEPTH+1 points over arguments 0..4
    localparam int ERF_TABLE_DEPTH = 256;
    localparam int ERF_IDX_W       = $clog2(ERF_TABLE_DEPTH);
    // argument is Q(8+FRAC_BITS); 4.0 spans 10+FRAC_BITS bits
    localparam int ERF_LSB         = 10 + FRAC_BITS - ERF_IDX_W;

    // Simpson step over 0..4 and the scale that makes erf(4) = 1.0
    localparam real ERF_H          = 4.0 / (2.0 * ERF_TABLE_DEPTH);
    localparam real ERF_SCALE      = real'(ONE) * (ERF_H / 3.0) * 1.1283791670955126
                                     / 0.9999999845827421;

    // Field widths
    localparam int SAMPLE_W        = 16;
    localparam int CHAN_W          = FRAC_BITS + 1;
    localparam int ALPHA_W         = FRAC_BITS + 2;
    localparam int SLOPE_W         = 16;
    localparam int DIFF_W          = FRAC_BITS + 2;
    localparam int ARG_W           = SLOPE_W + DIFF_W;
    localparam int MAG_W           = ARG_W - 1;
    localparam int COEF_W          = FRAC_BITS + 2;
    localparam int PROD_W          = COEF_W + CHAN_W;
    localparam int CALC_W          = CHAN_W + 3;

    // APB register file
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;
    localparam int REG_IDX_W       = 2;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_OFFSET_Y = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_SLOPE    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_OFFSET_X = REG_IDX_W'(2);

    localparam logic [CHAN_W-1:0]         OFFSET_Y_RST = CHAN_W'(2048);
    localparam logic signed [SLOPE_W-1:0] SLOPE_RST    = SLOPE_W'(2560);
    localparam logic [CHAN_W-1:0]         OFFSET_X_RST = CHAN_W'(2048);

    // Color coefficients, round(c * ONE)
    localparam int K_R_LO      = (2500 * ONE + 500) / 1000;
    localparam int K_G_LO      = (1950 * ONE + 500) / 1000;
    localparam int K_G_LO_BASE = (780  * ONE + 500) / 1000;
    localparam int K_B_LO      = (2350 * ONE + 500) / 1000;
    localparam int K_B_LO_BASE = (940  * ONE + 500) / 1000;
    localparam int K_G_MID     = (2857 * ONE + 500) / 1000;
    localparam int K_G_MID_OFF = (1143 * ONE + 500) / 1000;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef t_chan t_erf_tab [ERF_TABLE_DEPTH+1];
    typedef t_chan t_erf_seg [ERF_TABLE_DEPTH];

    // Erf at 4*i/DEPTH, Simpson rule on exp(-t*t), normalized so erf(4) = 1.0
    function automatic t_erf_tab erf_table_build();
        t_erf_tab tab;
        real      acc;
        real      g0;
        real      g1;
        real      g2;
        real      t1;
        real      t2;
        tab[0] = '0;
        acc    = 0.0;
        g0     = 1.0;
        for (int i = 0; i < ERF_TABLE_DEPTH; i++) begin
            t1  = ERF_H * real'(2 * i + 1);
            t2  = ERF_H * real'(2 * i + 2);
            g1  = $exp(-t1 * t1);
            g2  = $exp(-t2 * t2);
            acc = acc + g0 + 4.0 * g1 + g2;
            tab[i+1] = CHAN_W'($rtoi(acc * ERF_SCALE + 0.5));
            g0  = g2;
        end
        return tab;
    endfunction

    // Left point of each interpolation segment
    function automatic t_erf_seg erf_base(input t_erf_tab tab);
        t_erf_seg seg;
        for (int i = 0; i < ERF_TABLE_DEPTH; i++) begin
            seg[i] = tab[i];
        end
        return seg;
    endfunction

    // Rise over each interpolation segment
    function automatic t_erf_seg erf_step(input t_erf_tab tab);
        t_erf_seg seg;
        for (int i = 0; i < ERF_TABLE_DEPTH; i++) begin
            seg[i] = tab[i+1] - tab[i];
        end
        return seg;
    endfunction

    localparam t_erf_tab ERF_TAB  = erf_table_build();
    localparam t_erf_seg ERF_BASE = erf_base(ERF_TAB);
    localparam t_erf_seg ERF_STEP = erf_step(ERF_TAB);

    // k * x rounded half up, k and x unsigned
    function automatic logic [COEF_W-1:0] mul_round(input logic [COEF_W-1:0] k,
                                                     input logic [CHAN_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(k) * PROD_W'(x) + PROD_W'(HALF);
        return COEF_W'(p >> FRAC_BITS);
    endfunction

    // Clamp a signed value to 0..ONE
    function automatic t_chan clamp_unit(input logic signed [CALC_W-1:0] v);
        t_chan r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(CALC_W'(ONE))) begin
            r = CHAN_W'(ONE);
        end else begin
            r = v[CHAN_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/temperature_colormap_erf_alpha.sv @@
// Temperature color map with erf opacity ramp: six-stage pipeline and APB registers.
// Depends on tcea_pkg.
`default_nettype none

// One sample per clock: a request is taken whenever start is high (busy stays low,
// the pipeline never stalls) and its RGBA result passes through six register
// stages (clamp, multiply, color finish and erf table lookup, interpolation, alpha
// multiply, alpha round and saturate) to the o_red/o_green/o_blue/o_alpha ports,
// where it is shown for exactly one cycle, marked by o_valid. The receiver must
// take every result in the cycle it is shown. The alpha registers sit on APB at
// 0x0 (offset_y), 0x4 (slope) and 0x8 (offset_x); write them only while no
// request is in flight.
module temperature_colormap_erf_alpha (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample request
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tcea_pkg::SAMPLE_W-1:0] i_sample_value,
    // color result
    output logic                                 o_valid,
    output logic [tcea_pkg::CHAN_W-1:0]          o_red,
    output logic [tcea_pkg::CHAN_W-1:0]          o_green,
    output logic [tcea_pkg::CHAN_W-1:0]          o_blue,
    output logic [tcea_pkg::ALPHA_W-1:0]         o_alpha,
    // APB registers
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tcea_pkg::PADDR_W-1:0]         paddr,
    input  logic [tcea_pkg::PDATA_W-1:0]         pwdata,
    output logic [tcea_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import tcea_pkg::*;

    localparam int X5_W   = CHAN_W + 2;
    localparam int QP_W   = CHAN_W + ERF_LSB + 1;
    localparam int W_W    = CHAN_W + 1;
    localparam int AP_W   = CHAN_W + W_W;
    localparam int ARAW_W = AP_W - FRAC_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0]         r_alpha_offset_y;
    logic signed [SLOPE_W-1:0] r_alpha_slope;
    logic [CHAN_W-1:0]         r_alpha_offset_x;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_offset_y <= OFFSET_Y_RST;
            r_alpha_slope    <= SLOPE_RST;
            r_alpha_offset_x <= OFFSET_X_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ALPHA_OFFSET_Y: r_alpha_offset_y <= pwdata[CHAN_W-1:0];
                REG_ALPHA_SLOPE:    r_alpha_slope    <= $signed(pwdata[SLOPE_W-1:0]);
                REG_ALPHA_OFFSET_X: r_alpha_offset_x <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_ALPHA_OFFSET_Y: prdata = PDATA_W'(r_alpha_offset_y);
            REG_ALPHA_SLOPE:    prdata = PDATA_W'($unsigned(r_alpha_slope));
            REG_ALPHA_OFFSET_X: prdata = PDATA_W'(r_alpha_offset_x);
            default:            prdata = '0;
        endcase
    end

    // never stalls
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // Stage 1: clamp, segment select, distance to ramp center
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0]        n1_x;
    logic [X5_W-1:0]          n1_x5;
    logic                     n1_low;
    logic                     n1_mid;
    logic signed [DIFF_W-1:0] n1_diff;

    logic                     r1_v;
    logic [CHAN_W-1:0]        r1_x;
    logic                     r1_low;
    logic                     r1_mid;
    logic signed [DIFF_W-1:0] r1_diff;

    always_comb begin
        if (i_sample_value < 0) begin
            n1_x = '0;
        end else if (i_sample_value > $signed(SAMPLE_W'(ONE))) begin
            n1_x = CHAN_W'(ONE);
        end else begin
            n1_x = i_sample_value[CHAN_W-1:0];
        end
        n1_x5   = {2'b00, n1_x} + {n1_x, 2'b00};
        n1_low  = n1_x5 < X5_W'(2 * ONE);
        n1_mid  = !n1_low && ({n1_x, 2'b00} < X5_W'(3 * ONE));
        n1_diff = $signed({1'b0, n1_x}) - $signed({1'b0, r_alpha_offset_x});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
        end
        r1_x    <= n1_x;
        r1_low  <= n1_low;
        r1_mid  <= n1_mid;
        r1_diff <= n1_diff;
    end

    // ---------------------------------------------------------------
    // Stage 2: color slope products, erf argument
    // ---------------------------------------------------------------
    logic [COEF_W-1:0]       n2_mr;
    logic [COEF_W-1:0]       n2_mg;
    logic [COEF_W-1:0]       n2_mb;
    logic signed [ARG_W-1:0] n2_arg;

    logic                    r2_v;
    logic [CHAN_W-1:0]       r2_x;
    logic                    r2_low;
    logic                    r2_mid;
    logic [COEF_W-1:0]       r2_mr;
    logic [COEF_W-1:0]       r2_mg;
    logic [COEF_W-1:0]       r2_mb;
    logic signed [ARG_W-1:0] r2_arg;

    always_comb begin
        n2_mr  = mul_round(COEF_W'(K_R_LO), r1_x);
        n2_mg  = mul_round(r1_low ? COEF_W'(K_G_LO) : COEF_W'(K_G_MID), r1_x);
        n2_mb  = mul_round(COEF_W'(K_B_LO), r1_x);
        // Q8.8 times the signed 14-bit Q2.12 difference gives the Q10.20 erf argument
        n2_arg = ARG_W'(r_alpha_slope) * ARG_W'(r1_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_x   <= r1_x;
        r2_low <= r1_low;
        r2_mid <= r1_mid;
        r2_mr  <= n2_mr;
        r2_mg  <= n2_mg;
        r2_mb  <= n2_mb;
        r2_arg <= n2_arg;
    end

    // ---------------------------------------------------------------
    // Stage 3: finish colors, erf table lookup
    // ---------------------------------------------------------------
    logic signed [CALC_W-1:0] n3_tr;
    logic signed [CALC_W-1:0] n3_tg;
    logic signed [CALC_W-1:0] n3_tb;
    logic [ARG_W-1:0]         n3_abs;
    logic [MAG_W-1:0]         n3_mag;
    logic [ERF_IDX_W-1:0]     n3_idx;

    logic                     r3_v;
    logic [CHAN_W-1:0]        r3_red;
    logic [CHAN_W-1:0]        r3_green;
    logic [CHAN_W-1:0]        r3_blue;
    logic                     r3_neg;
    logic                     r3_sat;
    logic [CHAN_W-1:0]        r3_a;
    logic [CHAN_W-1:0]        r3_d;
    logic [ERF_LSB-1:0]       r3_frac;

    always_comb begin
        if (r2_low) begin
            n3_tr = $signed(CALC_W'(r2_mr));
            n3_tg = $signed(CALC_W'(K_G_LO_BASE)) - $signed(CALC_W'(r2_mg));
            n3_tb = $signed(CALC_W'(K_B_LO_BASE)) - $signed(CALC_W'(r2_mb));
        end else if (r2_mid) begin
            n3_tr = $signed(CALC_W'(ONE));
            n3_tg = $signed(CALC_W'(r2_mg)) - $signed(CALC_W'(K_G_MID_OFF));
            n3_tb = '0;
        end else begin
            n3_tr = $signed(CALC_W'(ONE));
            n3_tg = $signed(CALC_W'(ONE));
            n3_tb = $signed(CALC_W'({r2_x, 2'b00})) - $signed(CALC_W'(3 * ONE));
        end
        // erf is odd: look up the magnitude, restore the sign later
        n3_abs = r2_arg[ARG_W-1] ? ARG_W'(-r2_arg) : ARG_W'(r2_arg);
        n3_mag = n3_abs[MAG_W-1:0];
        n3_idx = n3_mag[ERF_LSB+ERF_IDX_W-1:ERF_LSB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_red   <= clamp_unit(n3_tr);
        r3_green <= clamp_unit(n3_tg);
        r3_blue  <= clamp_unit(n3_tb);
        r3_neg   <= r2_arg[ARG_W-1];
        r3_sat   <= |n3_mag[MAG_W-1:ERF_LSB+ERF_IDX_W];
        r3_a     <= ERF_BASE[n3_idx];
        r3_d     <= ERF_STEP[n3_idx];
        r3_frac  <= n3_mag[ERF_LSB-1:0];
    end

    // ---------------------------------------------------------------
    // Stage 4: linear interpolation, saturation beyond 4, sign
    // ---------------------------------------------------------------
    logic [QP_W-1:0]          n4_qp;
    logic [CHAN_W:0]          n4_sum;
    logic [CHAN_W-1:0]        n4_emag;
    logic signed [CHAN_W:0]   n4_e;

    logic                     r4_v;
    logic [CHAN_W-1:0]        r4_red;
    logic [CHAN_W-1:0]        r4_green;
    logic [CHAN_W-1:0]        r4_blue;
    logic signed [CHAN_W:0]   r4_e;

    always_comb begin
        n4_qp  = QP_W'(r3_d) * QP_W'(r3_frac) + QP_W'(1 << (ERF_LSB - 1));
        n4_sum = W_W'(r3_a) + W_W'(n4_qp >> ERF_LSB);
        if (r3_sat || n4_sum > W_W'(ONE)) begin
            n4_emag = CHAN_W'(ONE);
        end else begin
            n4_emag = n4_sum[CHAN_W-1:0];
        end
        n4_e = r3_neg ? -$signed({1'b0, n4_emag}) : $signed({1'b0, n4_emag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_red   <= r3_red;
        r4_green <= r3_green;
        r4_blue  <= r3_blue;
        r4_e     <= n4_e;
    end

    // ---------------------------------------------------------------
    // Stage 5: alpha = offset_y * (1 + erf), rounded
    // ---------------------------------------------------------------
    logic [W_W-1:0]    n5_w;

    logic              r5_v;
    logic [CHAN_W-1:0] r5_red;
    logic [CHAN_W-1:0] r5_green;
    logic [CHAN_W-1:0] r5_blue;
    logic [AP_W-1:0]   r5_prod;

    // 1 + erf lies in 0..2*ONE, so the modulo sum is exact
    assign n5_w = W_W'(ONE) + W_W'($unsigned(r4_e));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_red   <= r4_red;
        r5_green <= r4_green;
        r5_blue  <= r4_blue;
        r5_prod  <= AP_W'(r_alpha_offset_y) * AP_W'(n5_w) + AP_W'(HALF);
    end

    // ---------------------------------------------------------------
    // Stage 6: alpha saturation, result registers
    // ---------------------------------------------------------------
    logic [ARAW_W-1:0] n6_araw;

    assign n6_araw = r5_prod[AP_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r5_v;
        end
        o_red   <= r5_red;
        o_green <= r5_green;
        o_blue  <= r5_blue;
        if (n6_araw > ARAW_W'(2 * ONE)) begin
            o_alpha <= ALPHA_W'(2 * ONE);
        end else begin
            o_alpha <= n6_araw[ALPHA_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tcea_chk.sv @@
// Port-level checker for the temperature color map, bound to the top level.
// Depends on tcea_pkg and temperature_colormap_erf_alpha.
`default_nettype none

module tcea_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_valid,
    input logic [tcea_pkg::CHAN_W-1:0]          o_red,
    input logic [tcea_pkg::CHAN_W-1:0]          o_green,
    input logic [tcea_pkg::CHAN_W-1:0]          o_blue,
    input logic [tcea_pkg::ALPHA_W-1:0]         o_alpha,
    input logic                                 pready
);
    import tcea_pkg::*;

    localparam int LATENCY = 6;

    // every accepted request produces a result after the fixed latency
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("request without result after pipeline latency");

    // no result without a request the fixed latency earlier
    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching request");

    // results stay inside their fixed-point ranges
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= CHAN_W'(ONE)) && (o_green <= CHAN_W'(ONE)) &&
                    (o_blue <= CHAN_W'(ONE)) && (o_alpha <= ALPHA_W'(2 * ONE)))
        else $error("result outside 0..1.0 color or 0..2.0 alpha range");

    // register port never inserts wait states
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped low");

endmodule

bind temperature_colormap_erf_alpha tcea_chk u_tcea_chk (.*);

`default_nettype wire
